// ===== rtl/core/lp_pkg.sv =====
// lp_pkg: widths, register map, control structs and helper functions
// for the look-ahead peak limiter. No dependencies.
`default_nettype none
package lp_pkg;

   localparam int SAMPLE_BITS   = 24;
   localparam int SCALED_BITS   = SAMPLE_BITS + 4;
   localparam int PEAK_BITS     = SAMPLE_BITS + 3;
   localparam int GAIN_BITS     = 25;
   localparam int GAIN_FRAC     = 24;
   localparam int IGAIN_BITS    = 20;
   localparam int IGAIN_FRAC    = 16;
   localparam int CEIL_BITS     = 25;
   localparam int COEFF_BITS    = 24;
   localparam int LOOK_BITS     = 9;
   localparam int DELAY_DEPTH   = 512;
   localparam int DELAY_AW      = $clog2(DELAY_DEPTH);
   localparam int QUEUE_DEPTH   = 512;
   localparam int QUEUE_AW      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);
   localparam int STAMP_BITS    = 32;
   localparam int QWORD_BITS    = PEAK_BITS + STAMP_BITS;
   localparam int SPROD_BITS    = SAMPLE_BITS + IGAIN_BITS;
   localparam int PROD_BITS     = SCALED_BITS + GAIN_BITS;
   localparam int DIVIDEND_BITS = CEIL_BITS + SAMPLE_BITS - 1;
   localparam int DIV_CNT_BITS  = $clog2(DIVIDEND_BITS);
   localparam int ADDR_BITS     = 5;
   localparam int DATA_BITS     = 32;
   localparam int REG_IDX_BITS  = ADDR_BITS - 2;

   localparam logic [GAIN_BITS-1:0] UNITY_GAIN = GAIN_BITS'(64'd1 << GAIN_FRAC);

   localparam logic [REG_IDX_BITS-1:0] REG_INPUT_GAIN = 3'd0;
   localparam logic [REG_IDX_BITS-1:0] REG_CEILING    = 3'd1;
   localparam logic [REG_IDX_BITS-1:0] REG_RELEASE    = 3'd2;
   localparam logic [REG_IDX_BITS-1:0] REG_LINK       = 3'd3;
   localparam logic [REG_IDX_BITS-1:0] REG_LOOKAHEAD  = 3'd4;
   localparam logic [REG_IDX_BITS-1:0] REG_BYPASS     = 3'd5;

   localparam logic [IGAIN_BITS-1:0] RST_INPUT_GAIN = 20'd65536;
   localparam logic [CEIL_BITS-1:0]  RST_CEILING    = 25'd16207656;
   localparam logic [COEFF_BITS-1:0] RST_RELEASE    = 24'd16772848;
   localparam logic [LOOK_BITS-1:0]  RST_LOOKAHEAD  = 9'd240;

   typedef struct packed {
      logic                  start;
      logic                  clear;
      logic [DELAY_AW-1:0]   look;
      logic [DELAY_AW-1:0]   wp;
      logic [STAMP_BITS-1:0] fc;
      logic                  filled;
      logic [IGAIN_BITS-1:0] in_gain;
   } lane_ctl_type;

   typedef struct packed {
      logic                  start;
      logic                  clear;
      logic                  link;
      logic [CEIL_BITS-1:0]  ceiling;
      logic [COEFF_BITS-1:0] coeff;
   } gain_ctl_type;

   function automatic logic [QUEUE_AW-1:0] q_wrap(input logic [QCNT_BITS:0] s);
      logic [QCNT_BITS:0] r;
      r = (s >= (QCNT_BITS+1)'(QUEUE_DEPTH)) ? s - (QCNT_BITS+1)'(QUEUE_DEPTH) : s;
      return r[QUEUE_AW-1:0];
   endfunction

   function automatic logic [QUEUE_AW-1:0] q_next(input logic [QUEUE_AW-1:0] p);
      return q_wrap((QCNT_BITS+1)'(p) + (QCNT_BITS+1)'(1));
   endfunction

   function automatic logic [SCALED_BITS-1:0] mag_scaled(input logic [SCALED_BITS-1:0] d);
      return d[SCALED_BITS-1] ? SCALED_BITS'(0) - d : d;
   endfunction

   function automatic logic [SAMPLE_BITS-1:0] sat_out(input logic neg,
                                                     input logic [PROD_BITS-1:0] p);
      logic [PROD_BITS-1:0] r;
      logic [PROD_BITS-1:0] lim;
      r   = (p + (PROD_BITS'(1) << (GAIN_FRAC - 1))) >> GAIN_FRAC;
      lim = PROD_BITS'(1) << (SAMPLE_BITS - 1);
      if (neg) begin
         if (r > lim) r = lim;
         r = PROD_BITS'(0) - r;
      end else begin
         if (r > lim - PROD_BITS'(1)) r = lim - PROD_BITS'(1);
      end
      return r[SAMPLE_BITS-1:0];
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/lp_if.sv =====
// lp_if: valid/ready channel interfaces for sample frames and limited results
// depends on lp_pkg
`default_nettype none
interface lp_req_if import lp_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] left_in;
   logic signed [SAMPLE_BITS-1:0] right_in;
   modport source (output valid, output left_in, output right_in, input ready);
   modport sink (input valid, input left_in, input right_in, output ready);
endinterface

interface lp_rsp_if import lp_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] left_out;
   logic signed [SAMPLE_BITS-1:0] right_out;
   logic [GAIN_BITS-1:0]          left_gain;
   logic [GAIN_BITS-1:0]          right_gain;
   modport source (output valid, output left_out, output right_out, output left_gain,
                   output right_gain, input ready);
   modport sink (input valid, input left_out, input right_out, input left_gain,
                 input right_gain, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/lp_ram.sv =====
// lp_ram: generic single-write, single-read RAM with registered read data
// no dependencies
`default_nettype none
module lp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

// ===== rtl/core/lp_lane.sv =====
// lp_lane: one channel lane: input scaling, delay line and sliding-maximum queue
// depends on lp_pkg, lp_ram
`default_nettype none
module lp_lane import lp_pkg::*; (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire lane_ctl_type                  ctl,
   input  wire logic signed [SAMPLE_BITS-1:0] sample,
   output logic                               done,
   output logic [PEAK_BITS-1:0]               peak,
   output logic signed [SCALED_BITS-1:0]      delayed
);
   localparam logic [2:0] L_IDLE = 3'd0;
   localparam logic [2:0] L_MUL  = 3'd1;
   localparam logic [2:0] L_RND  = 3'd2;
   localparam logic [2:0] L_PRD  = 3'd3;
   localparam logic [2:0] L_PCMP = 3'd4;
   localparam logic [2:0] L_INS  = 3'd5;
   localparam logic [2:0] L_ARD  = 3'd6;
   localparam logic [2:0] L_ACMP = 3'd7;

   logic [2:0]              state_ff, state_in;
   logic [SPROD_BITS-1:0]   prod_ff, prod_in;
   logic                    neg_ff, neg_in;
   logic [PEAK_BITS-1:0]    v_ff, v_in;
   logic [QUEUE_AW-1:0]     head_ff, head_in;
   logic [QCNT_BITS-1:0]    cnt_ff, cnt_in;
   logic [PEAK_BITS-1:0]    peak_ff, peak_in;
   logic [SCALED_BITS-1:0]  dly_ff, dly_in;
   logic                    done_ff, done_in;

   logic                    q_wr_en, q_rd_en, d_wr_en, d_rd_en;
   logic [QUEUE_AW-1:0]     q_wr_addr, q_rd_addr;
   logic [QWORD_BITS-1:0]   q_wr_data, q_rd_data;
   logic [SCALED_BITS-1:0]  d_wr_data, d_rd_data;
   logic [DELAY_AW-1:0]     d_rd_addr;
   logic [DELAY_AW:0]       d_wrap_sum;
   logic                    d_valid;

   logic [SAMPLE_BITS-1:0]  mag_in;
   logic [SPROD_BITS-1:0]   round_sum;
   logic [PEAK_BITS-1:0]    scaled_mag;
   logic [PEAK_BITS-1:0]    rd_value;
   logic [STAMP_BITS-1:0]   rd_stamp, age;
   logic                    full;
   logic [QUEUE_AW-1:0]     head_adj, last_addr;
   logic [QCNT_BITS-1:0]    cnt_adj;

   assign mag_in     = sample[SAMPLE_BITS-1] ? SAMPLE_BITS'(0) - sample : sample;
   assign round_sum  = prod_ff + (SPROD_BITS'(1) << (IGAIN_FRAC - 1));
   assign scaled_mag = PEAK_BITS'(round_sum >> IGAIN_FRAC);
   assign rd_value   = q_rd_data[QWORD_BITS-1 -: PEAK_BITS];
   assign rd_stamp   = q_rd_data[STAMP_BITS-1:0];
   assign age        = ctl.fc - rd_stamp;
   assign full       = cnt_ff == QCNT_BITS'(QUEUE_DEPTH);
   assign head_adj   = full ? q_next(head_ff) : head_ff;
   assign cnt_adj    = full ? cnt_ff - QCNT_BITS'(1) : cnt_ff;
   assign last_addr  = q_wrap((QCNT_BITS+1)'(head_ff) + (QCNT_BITS+1)'(cnt_ff)
                              - (QCNT_BITS+1)'(1));
   assign d_wrap_sum = (DELAY_AW+1)'(ctl.wp) + (DELAY_AW+1)'(DELAY_DEPTH)
                       - (DELAY_AW+1)'(ctl.look);
   assign d_rd_addr  = (ctl.wp >= ctl.look) ? ctl.wp - ctl.look : d_wrap_sum[DELAY_AW-1:0];
   assign d_valid    = ctl.filled || (ctl.fc >= STAMP_BITS'(ctl.look));
   assign d_wr_data  = neg_in ? SCALED_BITS'(0) - {1'b0, scaled_mag} : {1'b0, scaled_mag};

   always_comb begin
      state_in  = state_ff;
      prod_in   = prod_ff;
      neg_in    = neg_ff;
      v_in      = v_ff;
      head_in   = head_ff;
      cnt_in    = cnt_ff;
      peak_in   = peak_ff;
      dly_in    = dly_ff;
      done_in   = 1'b0;
      q_wr_en   = 1'b0;
      q_rd_en   = 1'b0;
      d_wr_en   = 1'b0;
      d_rd_en   = 1'b0;
      q_wr_addr = q_wrap((QCNT_BITS+1)'(head_adj) + (QCNT_BITS+1)'(cnt_adj));
      q_wr_data = {v_ff, ctl.fc};
      q_rd_addr = head_ff;
      if (ctl.clear) begin
         head_in = '0;
         cnt_in  = '0;
      end
      unique case (state_ff)
         L_IDLE: begin
            if (ctl.start) state_in = L_MUL;
         end
         L_MUL: begin
            prod_in  = SPROD_BITS'(mag_in) * SPROD_BITS'(ctl.in_gain);
            neg_in   = sample[SAMPLE_BITS-1];
            state_in = L_RND;
         end
         L_RND: begin
            v_in     = scaled_mag;
            d_wr_en  = 1'b1;
            state_in = (cnt_ff != '0) ? L_PRD : L_INS;
         end
         L_PRD: begin
            q_rd_en   = 1'b1;
            q_rd_addr = last_addr;
            state_in  = L_PCMP;
         end
         L_PCMP: begin
            if (rd_value >= v_ff) begin
               state_in = L_INS;
            end else begin
               cnt_in   = cnt_ff - QCNT_BITS'(1);
               state_in = (cnt_ff != QCNT_BITS'(1)) ? L_PRD : L_INS;
            end
         end
         L_INS: begin
            q_wr_en  = 1'b1;
            head_in  = head_adj;
            cnt_in   = cnt_adj + QCNT_BITS'(1);
            d_rd_en  = 1'b1;
            state_in = L_ARD;
         end
         L_ARD: begin
            q_rd_en  = 1'b1;
            state_in = L_ACMP;
         end
         L_ACMP: begin
            if (age > STAMP_BITS'(ctl.look)) begin
               head_in  = q_next(head_ff);
               cnt_in   = cnt_ff - QCNT_BITS'(1);
               state_in = L_ARD;
            end else begin
               peak_in  = rd_value;
               dly_in   = d_valid ? d_rd_data : '0;
               done_in  = 1'b1;
               state_in = L_IDLE;
            end
         end
         default: state_in = L_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= L_IDLE;
         head_ff  <= '0;
         cnt_ff   <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         cnt_ff   <= cnt_in;
         done_ff  <= done_in;
      end
      prod_ff <= prod_in;
      neg_ff  <= neg_in;
      v_ff    <= v_in;
      peak_ff <= peak_in;
      dly_ff  <= dly_in;
   end

   lp_ram #(.WIDTH(QWORD_BITS), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock   (clock),
      .wr_en   (q_wr_en),
      .wr_addr (q_wr_addr),
      .wr_data (q_wr_data),
      .rd_en   (q_rd_en),
      .rd_addr (q_rd_addr),
      .rd_data (q_rd_data)
   );

   lp_ram #(.WIDTH(SCALED_BITS), .DEPTH(DELAY_DEPTH)) u_delay (
      .clock   (clock),
      .wr_en   (d_wr_en),
      .wr_addr (ctl.wp),
      .wr_data (d_wr_data),
      .rd_en   (d_rd_en),
      .rd_addr (d_rd_addr),
      .rd_data (d_rd_data)
   );

   assign done    = done_ff;
   assign peak    = peak_ff;
   assign delayed = dly_ff;
endmodule
`default_nettype wire

// ===== rtl/core/lp_gain.sv =====
// lp_gain: merges lane peaks into channel gains (divider, release) and applies them
// depends on lp_pkg
`default_nettype none
module lp_gain import lp_pkg::*; (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire gain_ctl_type                  ctl,
   input  wire logic [PEAK_BITS-1:0]          peak_l,
   input  wire logic [PEAK_BITS-1:0]          peak_r,
   input  wire logic signed [SCALED_BITS-1:0] dly_l,
   input  wire logic signed [SCALED_BITS-1:0] dly_r,
   output logic                               done,
   output logic signed [SAMPLE_BITS-1:0]      left_out,
   output logic signed [SAMPLE_BITS-1:0]      right_out,
   output logic [GAIN_BITS-1:0]               left_gain,
   output logic [GAIN_BITS-1:0]               right_gain
);
   localparam logic [2:0] G_IDLE = 3'd0;
   localparam logic [2:0] G_CHK  = 3'd1;
   localparam logic [2:0] G_DIV  = 3'd2;
   localparam logic [2:0] G_REL  = 3'd3;
   localparam logic [2:0] G_FIN  = 3'd4;
   localparam logic [2:0] G_AP0  = 3'd5;
   localparam logic [2:0] G_AP1  = 3'd6;
   localparam logic [2:0] G_AP2  = 3'd7;

   logic [2:0]               state_ff, state_in;
   logic                     ch_ff, ch_in;
   logic [PEAK_BITS-1:0]     peak_ff, peak_in;
   logic [PEAK_BITS-1:0]     rem_ff, rem_in;
   logic [DIVIDEND_BITS-1:0] dvd_ff, dvd_in;
   logic [GAIN_BITS-1:0]     req_ff, req_in;
   logic [DIV_CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [PROD_BITS-1:0]     prod_ff, prod_in;
   logic [GAIN_BITS-1:0]     gain_ff [2];
   logic [GAIN_BITS-1:0]     gain_in [2];
   logic [SAMPLE_BITS-1:0]   lout_ff, lout_in, rout_ff, rout_in;
   logic                     done_ff, done_in;

   logic [PEAK_BITS-1:0]     sel_peak;
   logic [PEAK_BITS:0]       rem2;
   logic                     ge;
   logic [GAIN_BITS-1:0]     g_cur, g_new;
   logic                     g_set;

   assign sel_peak = ch_ff ? peak_r
                   : (ctl.link ? ((peak_l > peak_r) ? peak_l : peak_r) : peak_l);
   assign rem2  = {rem_ff, dvd_ff[DIVIDEND_BITS-1]};
   assign ge    = rem2 >= {1'b0, peak_ff};
   assign g_cur = gain_ff[ch_ff];

   always_comb begin
      state_in   = state_ff;
      ch_in      = ch_ff;
      peak_in    = peak_ff;
      rem_in     = rem_ff;
      dvd_in     = dvd_ff;
      req_in     = req_ff;
      cnt_in     = cnt_ff;
      prod_in    = prod_ff;
      gain_in[0] = gain_ff[0];
      gain_in[1] = gain_ff[1];
      lout_in    = lout_ff;
      rout_in    = rout_ff;
      done_in    = 1'b0;
      g_set      = 1'b0;
      g_new      = g_cur;
      unique case (state_ff)
         G_IDLE: begin
            if (ctl.start) begin
               ch_in    = 1'b0;
               state_in = G_CHK;
            end
         end
         G_CHK: begin
            if ({sel_peak, 1'b0} > (PEAK_BITS+1)'(ctl.ceiling)) begin
               peak_in  = sel_peak;
               rem_in   = '0;
               dvd_in   = DIVIDEND_BITS'(ctl.ceiling) << (SAMPLE_BITS - 1);
               req_in   = '0;
               cnt_in   = '0;
               state_in = G_DIV;
            end else begin
               req_in   = UNITY_GAIN;
               state_in = G_REL;
            end
         end
         G_DIV: begin
            rem_in = ge ? PEAK_BITS'(rem2 - {1'b0, peak_ff}) : rem2[PEAK_BITS-1:0];
            req_in = {req_ff[GAIN_BITS-2:0], ge};
            dvd_in = dvd_ff << 1;
            cnt_in = cnt_ff + DIV_CNT_BITS'(1);
            if (cnt_ff == DIV_CNT_BITS'(DIVIDEND_BITS - 1)) state_in = G_REL;
         end
         G_REL: begin
            if (req_ff < g_cur) begin
               g_set = 1'b1;
               g_new = req_ff;
            end else begin
               prod_in  = PROD_BITS'(req_ff - g_cur) * PROD_BITS'(ctl.coeff);
               state_in = G_FIN;
            end
         end
         G_FIN: begin
            g_set = 1'b1;
            g_new = req_ff - GAIN_BITS'(prod_ff >> GAIN_FRAC);
         end
         G_AP0: begin
            prod_in  = PROD_BITS'(mag_scaled(dly_l)) * PROD_BITS'(gain_ff[0]);
            state_in = G_AP1;
         end
         G_AP1: begin
            lout_in  = sat_out(dly_l[SCALED_BITS-1], prod_ff);
            prod_in  = PROD_BITS'(mag_scaled(dly_r)) * PROD_BITS'(gain_ff[1]);
            state_in = G_AP2;
         end
         G_AP2: begin
            rout_in  = sat_out(dly_r[SCALED_BITS-1], prod_ff);
            done_in  = 1'b1;
            state_in = G_IDLE;
         end
         default: state_in = G_IDLE;
      endcase
      if (g_set) begin
         gain_in[ch_ff] = g_new;
         if (!ch_ff && !ctl.link) begin
            ch_in    = 1'b1;
            state_in = G_CHK;
         end else begin
            if (ctl.link) gain_in[1] = g_new;
            state_in = G_AP0;
         end
      end
      if (ctl.clear) begin
         gain_in[0] = UNITY_GAIN;
         gain_in[1] = UNITY_GAIN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= G_IDLE;
         ch_ff      <= 1'b0;
         gain_ff[0] <= UNITY_GAIN;
         gain_ff[1] <= UNITY_GAIN;
         done_ff    <= 1'b0;
      end else begin
         state_ff   <= state_in;
         ch_ff      <= ch_in;
         gain_ff[0] <= gain_in[0];
         gain_ff[1] <= gain_in[1];
         done_ff    <= done_in;
      end
      peak_ff <= peak_in;
      rem_ff  <= rem_in;
      dvd_ff  <= dvd_in;
      req_ff  <= req_in;
      cnt_ff  <= cnt_in;
      prod_ff <= prod_in;
      lout_ff <= lout_in;
      rout_ff <= rout_in;
   end

   assign done       = done_ff;
   assign left_out   = lout_ff;
   assign right_out  = rout_ff;
   assign left_gain  = gain_ff[0];
   assign right_gain = gain_ff[1];
endmodule
`default_nettype wire

// ===== rtl/core/lookahead_peak_limiter.sv =====
// lookahead_peak_limiter: top level, register port, frame sequencing, output register
// depends on lp_pkg, lp_if, lp_lane, lp_gain
//
// Stereo look-ahead brickwall limiter. One beat on req_chan carries a frame
// (left_in, right_in); each frame yields exactly one beat on rsp_chan with the
// delayed, limited samples and both channel gains (Q1.24, unity = 2^24).
// Registers are written over the APB port (byte address 4*index) while idle; the
// user must keep to this, as the block does not enforce it. Two lanes scale the
// input, write the delay line and update the sliding-maximum queue side by side;
// if the window peak exceeds the ceiling, the merge stage divides the ceiling by it
// (bit-serial divider, once per channel or once when linked), then applies release
// and the gains. Each queue entry popped or pruned in the slower lane lengthens a
// frame, as does a second division for unlinked channels. Bypass frames skip the
// lanes and the merge stage. req_chan is ready when no frame is in work.
// The result sits in an output register, so a new frame is taken while it waits;
// a stalled receiver holds that frame's finish until the register frees up.
// Reset (synchronous) restores register defaults and empties all state; the
// delay lines read as silence until written. Leaving bypass clears state again.
`default_nettype none
module lookahead_peak_limiter import lp_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   lp_req_if.sink                    req_chan,
   lp_rsp_if.source                  rsp_chan,
   input  wire logic                 psel,
   input  wire logic                 penable,
   input  wire logic                 pwrite,
   input  wire logic [ADDR_BITS-1:0] paddr,
   input  wire logic [DATA_BITS-1:0] pwdata,
   output logic      [DATA_BITS-1:0] prdata,
   output logic                      pready
);
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_START = 3'd1;
   localparam logic [2:0] ST_LANE  = 3'd2;
   localparam logic [2:0] ST_GAIN  = 3'd3;
   localparam logic [2:0] ST_OUT   = 3'd4;

   logic [IGAIN_BITS-1:0]   in_gain_ff;
   logic [CEIL_BITS-1:0]    ceiling_ff;
   logic [COEFF_BITS-1:0]   coeff_ff;
   logic                    link_ff;
   logic [LOOK_BITS-1:0]    look_ff;
   logic                    bypass_ff;
   logic                    was_active_ff;

   logic [2:0]              state_ff, state_in;
   logic [SAMPLE_BITS-1:0]  left_ff, right_ff;
   logic                    byp_item_ff;
   logic                    clr_ff;
   logic [1:0]              ldone_ff, ldone_in;
   logic [STAMP_BITS-1:0]   fc_ff;
   logic [DELAY_AW-1:0]     wp_ff;
   logic                    filled_ff;
   logic                    rsp_valid_ff;
   logic [SAMPLE_BITS-1:0]  lout_ff, rout_ff;
   logic [GAIN_BITS-1:0]    lgain_ff, rgain_ff;

   logic                    accept, wr_beat, slot_free, lanes_done;
   logic [REG_IDX_BITS-1:0] reg_idx;
   logic [DELAY_AW-1:0]     look_sat;
   lane_ctl_type            lane_ctl;
   gain_ctl_type            gain_ctl;
   logic                    done_l, done_r, gain_done;
   logic [PEAK_BITS-1:0]    peak_l, peak_r;
   logic [SCALED_BITS-1:0]  dly_l, dly_r;
   logic [SAMPLE_BITS-1:0]  res_l, res_r;
   logic [GAIN_BITS-1:0]    res_gl, res_gr;
   logic [SAMPLE_BITS-1:0]  lp_out_l, lp_out_r;
   logic [GAIN_BITS-1:0]    lp_gl, lp_gr;

   assign reg_idx   = paddr[ADDR_BITS-1:2];
   assign wr_beat   = psel && penable && pwrite;
   assign pready    = 1'b1;
   assign accept    = req_chan.valid && req_chan.ready;
   assign slot_free = !rsp_valid_ff || rsp_chan.ready;
   assign ldone_in  = ldone_ff | {done_r, done_l};
   assign lanes_done = &ldone_in;
   assign look_sat  = (32'(look_ff) > DELAY_DEPTH - 1) ? DELAY_AW'(DELAY_DEPTH - 1)
                                                      : DELAY_AW'(look_ff);

   always_comb begin
      unique case (reg_idx)
         REG_INPUT_GAIN: prdata = DATA_BITS'(in_gain_ff);
         REG_CEILING:    prdata = DATA_BITS'(ceiling_ff);
         REG_RELEASE:    prdata = DATA_BITS'(coeff_ff);
         REG_LINK:       prdata = DATA_BITS'(link_ff);
         REG_LOOKAHEAD:  prdata = DATA_BITS'(look_ff);
         REG_BYPASS:     prdata = DATA_BITS'(bypass_ff);
         default:        prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_gain_ff <= RST_INPUT_GAIN;
         ceiling_ff <= RST_CEILING;
         coeff_ff   <= RST_RELEASE;
         link_ff    <= 1'b1;
         look_ff    <= RST_LOOKAHEAD;
         bypass_ff  <= 1'b0;
      end else if (wr_beat) begin
         unique case (reg_idx)
            REG_INPUT_GAIN: in_gain_ff <= pwdata[IGAIN_BITS-1:0];
            REG_CEILING:    ceiling_ff <= pwdata[CEIL_BITS-1:0];
            REG_RELEASE:    coeff_ff   <= pwdata[COEFF_BITS-1:0];
            REG_LINK:       link_ff    <= pwdata[0];
            REG_LOOKAHEAD:  look_ff    <= pwdata[LOOK_BITS-1:0];
            REG_BYPASS:     bypass_ff  <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (accept) state_in = bypass_ff ? ST_OUT : ST_START;
         ST_START: state_in = ST_LANE;
         ST_LANE:  if (lanes_done) state_in = ST_GAIN;
         ST_GAIN:  if (gain_done) state_in = ST_OUT;
         ST_OUT:   if (slot_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         was_active_ff <= 1'b1;
         clr_ff        <= 1'b0;
         ldone_ff      <= '0;
         fc_ff         <= '0;
         wp_ff         <= '0;
         filled_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         byp_item_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (accept) begin
            byp_item_ff <= bypass_ff;
            if (bypass_ff) begin
               was_active_ff <= 1'b0;
            end else begin
               was_active_ff <= 1'b1;
               clr_ff        <= !was_active_ff;
               if (!was_active_ff) begin
                  fc_ff     <= '0;
                  wp_ff     <= '0;
                  filled_ff <= 1'b0;
               end
            end
         end
         if (state_ff == ST_START) begin
            clr_ff   <= 1'b0;
            ldone_ff <= '0;
         end
         if (state_ff == ST_LANE) ldone_ff <= ldone_in;
         if (state_ff == ST_OUT && slot_free) begin
            rsp_valid_ff <= 1'b1;
            if (!byp_item_ff) begin
               fc_ff <= fc_ff + STAMP_BITS'(1);
               wp_ff <= (wp_ff == DELAY_AW'(DELAY_DEPTH - 1)) ? '0 : wp_ff + DELAY_AW'(1);
               if (fc_ff >= STAMP_BITS'(DELAY_DEPTH - 1)) filled_ff <= 1'b1;
            end
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (accept) begin
         left_ff  <= req_chan.left_in;
         right_ff <= req_chan.right_in;
      end
      if (state_ff == ST_OUT && slot_free) begin
         lout_ff  <= res_l;
         rout_ff  <= res_r;
         lgain_ff <= res_gl;
         rgain_ff <= res_gr;
      end
   end

   assign res_l  = byp_item_ff ? left_ff : lp_out_l;
   assign res_r  = byp_item_ff ? right_ff : lp_out_r;
   assign res_gl = byp_item_ff ? UNITY_GAIN : lp_gl;
   assign res_gr = byp_item_ff ? UNITY_GAIN : lp_gr;

   always_comb begin
      lane_ctl.start   = state_ff == ST_START;
      lane_ctl.clear   = (state_ff == ST_START) && clr_ff;
      lane_ctl.look    = look_sat;
      lane_ctl.wp      = wp_ff;
      lane_ctl.fc      = fc_ff;
      lane_ctl.filled  = filled_ff;
      lane_ctl.in_gain = in_gain_ff;
      gain_ctl.start   = (state_ff == ST_LANE) && lanes_done;
      gain_ctl.clear   = (state_ff == ST_START) && clr_ff;
      gain_ctl.link    = link_ff;
      gain_ctl.ceiling = ceiling_ff;
      gain_ctl.coeff   = coeff_ff;
   end

   lp_lane u_lane_l (
      .clock   (clock),
      .reset   (reset),
      .ctl     (lane_ctl),
      .sample  (left_ff),
      .done    (done_l),
      .peak    (peak_l),
      .delayed (dly_l)
   );

   lp_lane u_lane_r (
      .clock   (clock),
      .reset   (reset),
      .ctl     (lane_ctl),
      .sample  (right_ff),
      .done    (done_r),
      .peak    (peak_r),
      .delayed (dly_r)
   );

   lp_gain u_gain (
      .clock      (clock),
      .reset      (reset),
      .ctl        (gain_ctl),
      .peak_l     (peak_l),
      .peak_r     (peak_r),
      .dly_l      (dly_l),
      .dly_r      (dly_r),
      .done       (gain_done),
      .left_out   (lp_out_l),
      .right_out  (lp_out_r),
      .left_gain  (lp_gl),
      .right_gain (lp_gr)
   );

   assign req_chan.ready      = state_ff == ST_IDLE;
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.left_out   = lout_ff;
   assign rsp_chan.right_out  = rout_ff;
   assign rsp_chan.left_gain  = lgain_ff;
   assign rsp_chan.right_gain = rgain_ff;

   a_gain_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (lgain_ff <= UNITY_GAIN && rgain_ff <= UNITY_GAIN))
      else $error("gain above unity");

   a_link_equal: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && link_ff) |-> (lgain_ff == rgain_ff))
      else $error("linked gains differ");

   a_gain_done_state: assert property (@(posedge clock) disable iff (reset)
      gain_done |-> (state_ff == ST_GAIN))
      else $error("merge stage finished outside its phase");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != ST_IDLE))
      else $error("frame accepted but sequencer idle");
endmodule
`default_nettype wire
